// ----- rtl/core/necir_pkg.sv -----
// Shared types, codes and the duration window check for the NEC IR frame decoder.
// Used by necir_sym_match, nec_ir_frame_decoder and necir_checker. No dependencies.
package necir_pkg;

  localparam int TICK_W    = 15;
  localparam int ADDR_BITS = 16;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [15:0]       code_t;
  typedef logic [5:0]        bit_idx_t;

  typedef enum logic {
    PH_IDLE,
    PH_BITS
  } phase_t;

  typedef enum logic [1:0] {
    EV_FRAME  = 2'd0,
    EV_REPEAT = 2'd1,
    EV_ERROR  = 2'd2
  } ev_kind_t;

  typedef enum logic [2:0] {
    CFG_LEADER_MARK  = 3'd0,
    CFG_LEADER_SPACE = 3'd1,
    CFG_REPEAT_SPACE = 3'd2,
    CFG_ZERO_MARK    = 3'd3,
    CFG_ZERO_SPACE   = 3'd4,
    CFG_ONE_MARK     = 3'd5,
    CFG_ONE_SPACE    = 3'd6,
    CFG_TOLERANCE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    tick_t leader_mark;
    tick_t leader_space;
    tick_t repeat_space;
    tick_t zero_mark;
    tick_t zero_space;
    tick_t one_mark;
    tick_t one_space;
    tick_t tolerance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    leader_mark:  15'd9000,
    leader_space: 15'd4500,
    repeat_space: 15'd2250,
    zero_mark:    15'd560,
    zero_space:   15'd560,
    one_mark:     15'd560,
    one_space:    15'd1690,
    tolerance:    15'd200
  };

  // Symbol classification results
  typedef struct packed {
    logic leader;
    logic rpt;
    logic one;
    logic zero;
  } sym_match_t;

  // Strict window: nom - tol < t < nom + tol, lower bound clamped at zero
  function automatic logic tick_within(tick_t t, tick_t nom, tick_t tol);
    logic [TICK_W:0] hi;
    tick_t           lo;
    hi = {1'b0, nom} + {1'b0, tol};
    lo = (nom > tol) ? tick_t'(nom - tol) : '0;
    return ({1'b0, t} < hi) && (t > lo);
  endfunction

endpackage

// ----- rtl/core/necir_sym_match.sv -----
// Classifies one mark/space symbol against the leader, repeat, one and zero windows.
// Depends on necir_pkg.
module necir_sym_match (
  input  necir_pkg::tick_t      mark_ticks,
  input  necir_pkg::tick_t      space_ticks,
  input  necir_pkg::cfg_t       cfg,
  output necir_pkg::sym_match_t match
);

  logic mark_leader;

  assign mark_leader = necir_pkg::tick_within(mark_ticks, cfg.leader_mark, cfg.tolerance);

  // repeat code reuses the leader mark
  assign match.leader = mark_leader &&
    necir_pkg::tick_within(space_ticks, cfg.leader_space, cfg.tolerance);
  assign match.rpt    = mark_leader &&
    necir_pkg::tick_within(space_ticks, cfg.repeat_space, cfg.tolerance);
  assign match.one    =
    necir_pkg::tick_within(mark_ticks, cfg.one_mark, cfg.tolerance) &&
    necir_pkg::tick_within(space_ticks, cfg.one_space, cfg.tolerance);
  assign match.zero   =
    necir_pkg::tick_within(mark_ticks, cfg.zero_mark, cfg.tolerance) &&
    necir_pkg::tick_within(space_ticks, cfg.zero_space, cfg.tolerance);

endmodule

// ----- rtl/core/nec_ir_frame_decoder.sv -----
// NEC IR frame decoder top level: input register, symbol decode, result register.
// Depends on necir_pkg and necir_sym_match.
//
// Usage:
//  - Input stream (in_*): one IR symbol per transaction. in_tuser flags the
//    first symbol of a capture; in_tdata carries mark and space durations in ticks.
//  - Output stream (out_*): at most one event per symbol. out_tuser is the event
//    kind (frame, repeat, error); out_tdata carries address and command.
//    A leader, a mid-frame bit, or a stray symbol outside a capture gives no event.
//  - Config port (cfg_*): eight 15-bit timing registers, write only, indexed as
//    leader mark/space, repeat space, zero mark/space, one mark/space, tolerance.
//    Write only while the decoder is idle.
//  - Pipeline: a symbol is registered in the input register, its event in the result register.
//  - Throughput: one symbol per cycle while the output is not stalled; the single stage of window
//    compares and bit insertion between the input and result registers sets this.
//  - Stall: a held result keeps the input register full; one more symbol is
//    taken into the input register, then in_tready drops until out_tready.
//  - Reset (rst_n low, synchronous): timing registers return to defaults, the
//    stored last code clears to zero, both stages empty, no capture in progress.
module nec_ir_frame_decoder #(
  parameter int FRAME_BITS = 32   // 2..32 data bits per frame
) (
  input  logic        clk,
  input  logic        rst_n,
  // input symbols
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [14:0] mark_ticks, [29:15] space_ticks, [31:30] zero
  input  logic        in_tuser,   // [0] capture_start
  // decoded events
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] ir_address, [31:16] ir_command
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  // config
  necir_pkg::cfg_t cfg_r;

  // input register
  logic             s1_valid_r;
  logic             s1_start_r;
  necir_pkg::tick_t s1_mark_r;
  necir_pkg::tick_t s1_space_r;

  // decoder state
  necir_pkg::phase_t phase_r,      phase_nxt;
  logic [CNT_W-1:0]  bit_count_r,  bit_count_nxt;
  necir_pkg::code_t  addr_shift_r, addr_shift_nxt;
  necir_pkg::code_t  cmd_shift_r,  cmd_shift_nxt;
  necir_pkg::code_t  last_addr_r,  last_addr_nxt;
  necir_pkg::code_t  last_cmd_r,   last_cmd_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  necir_pkg::ev_kind_t out_kind_r,  out_kind_nxt;
  necir_pkg::code_t    out_addr_r,  out_addr_nxt;
  necir_pkg::code_t    out_cmd_r,   out_cmd_nxt;

  logic                  in_acc;
  logic                  s1_adv;
  logic                  out_free;
  necir_pkg::sym_match_t match;
  necir_pkg::bit_idx_t   bit_idx;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= necir_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (necir_pkg::cfg_idx_t'(cfg_index))
        necir_pkg::CFG_LEADER_MARK:  cfg_r.leader_mark  <= cfg_data;
        necir_pkg::CFG_LEADER_SPACE: cfg_r.leader_space <= cfg_data;
        necir_pkg::CFG_REPEAT_SPACE: cfg_r.repeat_space <= cfg_data;
        necir_pkg::CFG_ZERO_MARK:    cfg_r.zero_mark    <= cfg_data;
        necir_pkg::CFG_ZERO_SPACE:   cfg_r.zero_space   <= cfg_data;
        necir_pkg::CFG_ONE_MARK:     cfg_r.one_mark     <= cfg_data;
        necir_pkg::CFG_ONE_SPACE:    cfg_r.one_space    <= cfg_data;
        necir_pkg::CFG_TOLERANCE:    cfg_r.tolerance    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_start_r <= in_tuser;
      s1_mark_r  <= in_tdata[14:0];
      s1_space_r <= in_tdata[29:15];
    end
  end

  necir_sym_match u_match (
    .mark_ticks  (s1_mark_r),
    .space_ticks (s1_space_r),
    .cfg         (cfg_r),
    .match       (match)
  );

  assign bit_idx = necir_pkg::bit_idx_t'(bit_count_r);

  // next state and result
  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    addr_shift_nxt = addr_shift_r;
    cmd_shift_nxt  = cmd_shift_r;
    last_addr_nxt  = last_addr_r;
    last_cmd_nxt   = last_cmd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_cmd_nxt    = out_cmd_r;

    if (s1_adv) begin
      if (s1_start_r) begin
        // leader wins over repeat; a partial frame is dropped
        if (match.leader) begin
          phase_nxt      = necir_pkg::PH_BITS;
          bit_count_nxt  = '0;
          addr_shift_nxt = '0;
          cmd_shift_nxt  = '0;
        end else begin
          phase_nxt     = necir_pkg::PH_IDLE;
          out_valid_nxt = 1'b1;
          if (match.rpt) begin
            out_kind_nxt = necir_pkg::EV_REPEAT;
            out_addr_nxt = last_addr_r;
            out_cmd_nxt  = last_cmd_r;
          end else begin
            out_kind_nxt = necir_pkg::EV_ERROR;
            out_addr_nxt = '0;
            out_cmd_nxt  = '0;
          end
        end
      end else if (phase_r == necir_pkg::PH_BITS) begin
        if (!match.one && !match.zero) begin
          phase_nxt     = necir_pkg::PH_IDLE;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = necir_pkg::EV_ERROR;
          out_addr_nxt  = '0;
          out_cmd_nxt   = '0;
        end else begin
          // a symbol matching both windows counts as a one
          for (int i = 0; i < necir_pkg::ADDR_BITS; i++) begin
            if (match.one && bit_idx == necir_pkg::bit_idx_t'(i)) begin
              addr_shift_nxt[i] = 1'b1;
            end
            if (match.one && bit_idx == necir_pkg::bit_idx_t'(i + necir_pkg::ADDR_BITS)) begin
              cmd_shift_nxt[i] = 1'b1;
            end
          end
          if (bit_count_r == CNT_W'(FRAME_BITS - 1)) begin
            phase_nxt     = necir_pkg::PH_IDLE;
            bit_count_nxt = CNT_W'(FRAME_BITS);
            last_addr_nxt = addr_shift_nxt;
            last_cmd_nxt  = cmd_shift_nxt;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = necir_pkg::EV_FRAME;
            out_addr_nxt  = addr_shift_nxt;
            out_cmd_nxt   = cmd_shift_nxt;
          end else begin
            bit_count_nxt = bit_count_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= necir_pkg::PH_IDLE;
      bit_count_r  <= '0;
      addr_shift_r <= '0;
      cmd_shift_r  <= '0;
      last_addr_r  <= '0;
      last_cmd_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      addr_shift_r <= addr_shift_nxt;
      cmd_shift_r  <= cmd_shift_nxt;
      last_addr_r  <= last_addr_nxt;
      last_cmd_r   <= last_cmd_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_cmd_r  <= out_cmd_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_cmd_r, out_addr_r};

endmodule

// ----- rtl/core/necir_checker.sv -----
// Port-level checks for nec_ir_frame_decoder, bound to the top level.
// Depends on necir_pkg.
module necir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output event changed while stalled");

  // error events carry no code
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == necir_pkg::EV_ERROR |-> out_tdata == 32'd0)
    else $error("error event with nonzero data");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("event valid after reset");

  // a fresh event must follow an earlier symbol transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("event without matching input transaction");

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
